/* sv/cfe_pkg.sv */
// Package with the request codes, the hash seed and the reset relocation limit of the cuckoo filter engine.
`timescale 1ns / 1ps

package cfe_pkg;

  // Request codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Seed of the 16-bit DJB hash.
  localparam logic [15:0] DJB_SEED = 16'd5381;

  // Relocation limit after reset.
  localparam logic [7:0] MAX_RELOC_RESET = 8'd8;

endpackage

/* sv/cfe_hash.sv */
// Combinational 16-bit DJB hash of a 16-bit value, low byte first.
`timescale 1ns / 1ps

module cfe_hash (
  input  logic [15:0] value,
  output logic [15:0] hash
);

  logic [15:0] h0;
  logic [15:0] h1;

  // Two rounds of h = h*33 + byte, kept to 16 bits.
  always_comb begin
    h0 = (cfe_pkg::DJB_SEED << 5) + cfe_pkg::DJB_SEED + {8'd0, value[7:0]};
    h1 = (h0 << 5) + h0 + {8'd0, value[15:8]};
  end

  assign hash = h1;

endmodule

/* sv/cfe_table.sv */
// Bucket table: synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps

module cfe_table #(
  parameter int DEPTH = 128,
  parameter int IW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [IW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/cfe_ctrl.sv */
// Request sequencer: hashing, bucket checks, relocation walk, table sweep and result register.
`timescale 1ns / 1ps

module cfe_ctrl #(
  parameter int BUCKET_COUNT = 128,
  parameter int IW           = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_action,
  input  logic [15:0]   in_key,
  input  logic          in_evict_choice,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_ok,
  output logic [7:0]    out_relocations,
  output logic [15:0]   out_key_fingerprint,
  // configuration channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data,
  // table port
  output logic          tbl_wr_en,
  output logic [IW-1:0] tbl_wr_addr,
  output logic [15:0]   tbl_wr_data,
  output logic [IW-1:0] tbl_rd_addr,
  input  logic [15:0]   tbl_rd_data
);

  localparam logic [IW-1:0] IDX_MASK = IW'(BUCKET_COUNT - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUCKET_COUNT - 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_FP, ST_HASH, ST_RD2, ST_CHK, ST_ALT, ST_EVAL, ST_CLEAR, ST_DONE
  } state_t;

  state_t        state_r;
  logic [1:0]    action_r;
  logic [15:0]   key_r;
  logic          choice_r;
  logic [15:0]   fp_r;
  logic [IW-1:0] i2_r;
  logic [15:0]   b1_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] alt_r;
  logic [15:0]   victim_r;
  logic [7:0]    count_r;
  logic          res_ok_r;
  logic [IW-1:0] clr_addr_r;
  logic [7:0]    max_reloc_r;
  logic          out_valid_r;
  logic          out_ok_r;
  logic [7:0]    out_reloc_r;
  logic [15:0]   out_fp_r;

  logic [15:0]   hash_in;
  logic [15:0]   hash_out;
  logic [IW-1:0] i1;
  logic [IW-1:0] alt;
  logic          out_free;

  // One shared hash unit: key in ST_FP, fingerprint in ST_HASH, victim in ST_ALT.
  always_comb begin
    case (state_r)
      ST_FP:   hash_in = key_r;
      ST_ALT:  hash_in = victim_r;
      default: hash_in = fp_r;
    endcase
  end

  cfe_hash u_hash (
    .value (hash_in),
    .hash  (hash_out)
  );

  assign i1       = fp_r[IW-1:0] & IDX_MASK;
  assign alt      = (idx_r ^ (hash_out[IW-1:0] & IDX_MASK)) & IDX_MASK;
  assign out_free = !out_valid_r || !out_stall;

  // Table read address and write request per state.
  always_comb begin
    tbl_rd_addr = i1;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = clr_addr_r;
    tbl_wr_data = 16'd0;
    case (state_r)
      ST_RD2: tbl_rd_addr = i2_r;
      ST_ALT: tbl_rd_addr = alt;
      ST_INIT, ST_CLEAR: begin
        tbl_wr_en = 1'b1;
      end
      ST_CHK: begin
        if (action_r == cfe_pkg::ACT_INSERT) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = fp_r;
          if (b1_r == 16'd0) begin
            tbl_wr_addr = i1;
          end else if (tbl_rd_data == 16'd0) begin
            tbl_wr_addr = i2_r;
          end else begin
            tbl_wr_addr = choice_r ? i1 : i2_r;
          end
        end
      end
      ST_EVAL: begin
        tbl_wr_addr = alt_r;
        tbl_wr_data = victim_r;
        tbl_wr_en   = (tbl_rd_data == 16'd0) || (count_r < max_reloc_r);
      end
      default: begin
      end
    endcase
  end

  // State, working registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      max_reloc_r <= cfe_pkg::MAX_RELOC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_reloc_r <= cfg_data;
      end
      // The held result leaves; ST_DONE sets the flag itself when a new one is loaded.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_IDX) begin
            clr_addr_r <= '0;
            state_r    <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            key_r    <= in_key;
            choice_r <= in_evict_choice;
            state_r  <= ST_FP;
          end
        end
        ST_FP: begin
          fp_r     <= hash_out;
          count_r  <= 8'd0;
          res_ok_r <= 1'b0;
          case (action_r)
            cfe_pkg::ACT_INSERT, cfe_pkg::ACT_LOOKUP: state_r <= ST_HASH;
            cfe_pkg::ACT_CLEAR:                       state_r <= ST_CLEAR;
            default:                                  state_r <= ST_DONE;
          endcase
        end
        ST_HASH: begin
          i2_r    <= (i1 ^ (hash_out[IW-1:0] & IDX_MASK)) & IDX_MASK;
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          b1_r    <= tbl_rd_data;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (action_r == cfe_pkg::ACT_LOOKUP) begin
            res_ok_r <= (b1_r == fp_r) || (tbl_rd_data == fp_r);
            state_r  <= ST_DONE;
          end else if (b1_r == 16'd0 || tbl_rd_data == 16'd0) begin
            res_ok_r <= 1'b1;
            state_r  <= ST_DONE;
          end else begin
            // Both buckets full: evict at the chosen bucket and walk.
            idx_r    <= choice_r ? i1 : i2_r;
            victim_r <= choice_r ? b1_r : tbl_rd_data;
            state_r  <= ST_ALT;
          end
        end
        ST_ALT: begin
          alt_r   <= alt;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (tbl_rd_data == 16'd0) begin
            res_ok_r <= 1'b1;
            state_r  <= ST_DONE;
          end else if (count_r >= max_reloc_r) begin
            res_ok_r <= 1'b0;
            state_r  <= ST_DONE;
          end else begin
            count_r  <= count_r + 8'd1;
            idx_r    <= alt_r;
            victim_r <= tbl_rd_data;
            state_r  <= ST_ALT;
          end
        end
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_IDX) begin
            clr_addr_r <= '0;
            res_ok_r   <= 1'b1;
            state_r    <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Wait for the result register to be free of the previous result.
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_reloc_r <= count_r;
            out_fp_r    <= fp_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_relocations     = out_reloc_r;
  assign out_key_fingerprint = out_fp_r;

endmodule

/* sv/cuckoo_filter_engine.sv */
// Top level of the cuckoo filter engine: sequencer and bucket table memory.
// Usage:
//   Requests arrive on in_valid / in_stall with in_action (0 insert, 1 lookup,
//   2 clear), in_key and in_evict_choice. A transfer takes place on a rising edge
//   with in_valid high and in_stall low. One result per request leaves on
//   out_valid / out_stall with out_ok, out_relocations and out_key_fingerprint.
//   The user must write the relocation limit through cfg_valid / cfg_ready / cfg_data
//   only while the engine is idle; the block itself does not enforce this. cfg_ready is always high.
// Sequence (one request in flight, set by the single table read port):
//   lookup and insert hash the key to the fingerprint, hash that to the second
//   bucket, then read and check both buckets; an insert that evicts then walks,
//   each step a table read followed by a write back; a clear sweeps the table one
//   entry a cycle; action 3 goes straight to the result.
// Reset (synchronous, rst_n low) sets the limit to 8 and starts a clearing pass
//   over all BUCKET_COUNT entries, during which in_stall stays high.
// A stalled result is held in the output register; the next request is still
//   taken and worked on, and only its result waits until the held one is gone.
`timescale 1ns / 1ps

module cuckoo_filter_engine #(
  parameter int BUCKET_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_key,
  input  logic        in_evict_choice,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [7:0]  out_relocations,
  output logic [15:0] out_key_fingerprint,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IW = $clog2(BUCKET_COUNT);

  logic          tbl_wr_en;
  logic [IW-1:0] tbl_wr_addr;
  logic [15:0]   tbl_wr_data;
  logic [IW-1:0] tbl_rd_addr;
  logic [15:0]   tbl_rd_data;

  // Sequencer.
  cfe_ctrl #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .IW           (IW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_evict_choice     (in_evict_choice),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_relocations     (out_relocations),
    .out_key_fingerprint (out_key_fingerprint),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .tbl_wr_en           (tbl_wr_en),
    .tbl_wr_addr         (tbl_wr_addr),
    .tbl_wr_data         (tbl_wr_data),
    .tbl_rd_addr         (tbl_rd_addr),
    .tbl_rd_data         (tbl_rd_data)
  );

  // Bucket table.
  cfe_table #(
    .DEPTH (BUCKET_COUNT),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the cuckoo filter engine: predicting scoreboard and stimulus.
`timescale 1ns / 1ps

module tb_top;

  localparam int BUCKET_COUNT = 128;
  localparam int IDX_MASK = BUCKET_COUNT - 1;
  localparam int HALF_PERIOD_NS = 6;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 600;
  localparam longint TIMEOUT_NS = 64'd50_000_000;

  // One result as the engine should report it.
  typedef struct {
    logic        ok;
    logic [7:0]  relocations;
    logic [15:0] fingerprint;
  } filter_result_t;

  // Keeps a shadow of the bucket table and the relocation limit, and queues the
  // result that each accepted request must produce.
  class cuckoo_scoreboard;
    logic [15:0]    buckets[BUCKET_COUNT];
    logic [7:0]     reloc_limit;
    filter_result_t pending_q[$];
    int unsigned    failures;

    function new();
      wipe_table();
      reloc_limit = cfe_pkg::MAX_RELOC_RESET;
      failures = 0;
    endfunction

    function void wipe_table();
      for (int i = 0; i < BUCKET_COUNT; i++) buckets[i] = 16'h0000;
    endfunction

    // 16-bit DJB hash over the low byte and then the high byte.
    function logic [15:0] hash16(logic [15:0] value);
      logic [31:0] h;
      h = {16'h0000, cfe_pkg::DJB_SEED};
      h = (h * 33 + value[7:0]) & 32'h0000_FFFF;
      h = (h * 33 + value[15:8]) & 32'h0000_FFFF;
      return h[15:0];
    endfunction

    function int partner_index(int idx, logic [15:0] fp);
      return (idx ^ (int'(hash16(fp)) & IDX_MASK)) & IDX_MASK;
    endfunction

    function void set_limit(logic [7:0] value);
      reloc_limit = value;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    // Works out the result of one accepted request and updates the shadow table.
    function void note_request(cfe_pkg::action_t act, logic [15:0] key, logic choice);
      filter_result_t res;
      logic [15:0]    fp;
      logic [15:0]    victim;
      logic [15:0]    held;
      int             first_idx;
      int             second_idx;
      int             idx;
      int             alt;
      int unsigned    swaps;
      fp = hash16(key);
      first_idx = int'(fp) & IDX_MASK;
      second_idx = partner_index(first_idx, fp);
      swaps = 0;
      res.ok = 1'b0;
      case (act)
        cfe_pkg::ACT_INSERT: begin
          if (buckets[first_idx] == 16'h0000) begin
            buckets[first_idx] = fp;
            res.ok = 1'b1;
          end else if (buckets[second_idx] == 16'h0000) begin
            buckets[second_idx] = fp;
            res.ok = 1'b1;
          end else begin
            // Both buckets taken: evict and walk the victims to their other bucket.
            idx = choice ? first_idx : second_idx;
            victim = buckets[idx];
            buckets[idx] = fp;
            forever begin
              alt = partner_index(idx, victim);
              if (buckets[alt] == 16'h0000) begin
                buckets[alt] = victim;
                res.ok = 1'b1;
                break;
              end
              if (swaps >= reloc_limit) begin
                break;
              end
              swaps++;
              idx = alt;
              held = buckets[alt];
              buckets[alt] = victim;
              victim = held;
            end
          end
        end
        cfe_pkg::ACT_LOOKUP: begin
          res.ok = (buckets[first_idx] == fp) || (buckets[second_idx] == fp);
        end
        cfe_pkg::ACT_CLEAR: begin
          wipe_table();
          res.ok = 1'b1;
        end
        default: begin
          res.ok = 1'b0;
        end
      endcase
      res.relocations = swaps[7:0];
      res.fingerprint = fp;
      pending_q.push_back(res);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(logic ok, logic [7:0] relocations, logic [15:0] fingerprint);
      filter_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result ok=%0b relocations=%0d fingerprint=%h",
                 $time, ok, relocations, fingerprint);
        failures++;
        return;
      end
      want = pending_q.pop_front();
      if (ok !== want.ok) begin
        $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, ok);
        failures++;
      end
      if (relocations !== want.relocations) begin
        $display("%0t: relocations mismatch, expected %0d, actual %0d",
                 $time, want.relocations, relocations);
        failures++;
      end
      if (fingerprint !== want.fingerprint) begin
        $display("%0t: fingerprint mismatch, expected %h, actual %h",
                 $time, want.fingerprint, fingerprint);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = cfe_pkg::ACT_LOOKUP;
  logic [15:0] in_key = 16'h0000;
  logic        in_evict_choice = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [7:0]  out_relocations;
  logic [15:0] out_key_fingerprint;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  cuckoo_scoreboard sb;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      hold_request = 0;
  logic [15:0]      key_pool[$];

  cuckoo_filter_engine #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_key             (in_key),
    .in_evict_choice    (in_evict_choice),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_relocations    (out_relocations),
    .out_key_fingerprint(out_key_fingerprint),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // Free-running clock.
  always #(HALF_PERIOD_NS) clk = ~clk;

  // Offers one request, with random idle cycles first, and holds it until the transfer.
  task automatic send_request(input cfe_pkg::action_t act, input logic [15:0] key,
                              input logic choice);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= key;
    in_evict_choice <= choice;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, key, choice);
  endtask

  // Stops offering requests and waits until every expected result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the relocation limit; the engine must be idle.
  task automatic write_limit(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(value);
  endtask

  // Random requests: mostly inserts and lookups of stored keys, some clears and no-ops.
  task automatic random_phase(input int count);
    int unsigned pick;
    logic [15:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      key = 16'($urandom());
      if (pick < 3) begin
        key_pool.delete();
        send_request(cfe_pkg::ACT_CLEAR, key, 1'($urandom()));
      end else if (pick < 5) begin
        send_request(cfe_pkg::ACT_NONE, key, 1'($urandom()));
      end else if (pick < 35) begin
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        send_request(cfe_pkg::ACT_LOOKUP, key, 1'($urandom()));
      end else begin
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 15) begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (key_pool.size() < 256) begin
          key_pool.push_back(key);
        end
        send_request(cfe_pkg::ACT_INSERT, key, 1'($urandom()));
      end
    end
  endtask

  // Result side: checks each transfer and stalls at random or for a long hold-off.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_ok, out_relocations, out_key_fingerprint);
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Main sequence: reset, directed requests, then random phases over several limits.
  initial begin : stimulus
    logic [15:0] zero_fp_key;
    logic [15:0] twin_key;
    logic [7:0]  limits[8];
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    sb = new();
    zero_fp_key = 16'h0000;
    twin_key = 16'h1234;
    for (int k = 0; k < 65536; k++) begin
      if (sb.hash16(16'(k)) == 16'h0000) begin
        zero_fp_key = 16'(k);
        break;
      end
    end
    limits = '{8'd8, 8'd0, 8'd255, 8'd3, 8'd1, 8'd0, 8'd16, 8'd8};
    limits[5] = 8'($urandom());
    idle_set = '{0, 67, 0, 36};
    stall_set = '{0, 0, 67, 36};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every action, the zero fingerprint, failed inserts.
    send_request(cfe_pkg::ACT_LOOKUP, 16'h0000, 1'b0);
    send_request(cfe_pkg::ACT_INSERT, 16'h0000, 1'b0);
    send_request(cfe_pkg::ACT_INSERT, 16'hFFFF, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, 16'hFFFF, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, 16'h0000, 1'b0);
    send_request(cfe_pkg::ACT_NONE, 16'hFFFF, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, zero_fp_key, 1'b0);
    send_request(cfe_pkg::ACT_INSERT, zero_fp_key, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, zero_fp_key, 1'b0);
    // The same key four times: the first two fill both buckets, the later ones force failed relocation walks.
    send_request(cfe_pkg::ACT_INSERT, twin_key, 1'b0);
    send_request(cfe_pkg::ACT_INSERT, twin_key, 1'b1);
    send_request(cfe_pkg::ACT_INSERT, twin_key, 1'b0);
    send_request(cfe_pkg::ACT_INSERT, twin_key, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, twin_key, 1'b0);
    send_request(cfe_pkg::ACT_CLEAR, 16'hFFFF, 1'b1);
    send_request(cfe_pkg::ACT_LOOKUP, twin_key, 1'b0);
    wait_idle();
    write_limit(8'd0);
    for (int n = 0; n < 3; n++) send_request(cfe_pkg::ACT_INSERT, twin_key, 1'b1);
    send_request(cfe_pkg::ACT_CLEAR, 16'h0000, 1'b0);
    wait_idle();
    write_limit(8'd255);
    for (int n = 0; n < 3; n++) send_request(cfe_pkg::ACT_INSERT, twin_key, 1'(n));
    send_request(cfe_pkg::ACT_CLEAR, 16'h0000, 1'b0);
    wait_idle();

    // Random part: each phase has its own limit and idling pattern.
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      idle_pct = idle_set[p % 4];
      stall_pct = stall_set[p % 4];
      if (p == 0) hold_request = HOLD_OFF_CYCLES;
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    // Let any stray result appear before the verdict.
    idle_pct = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("** cuckoo_filter_engine: PASSED **");
    end else begin
      $display("** cuckoo_filter_engine: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** cuckoo_filter_engine: FAILED **");
    $finish;
  end

endmodule
